>>> hdl/urcd_pkg.sv
// shared types and constants for the udp receive check and demux block
package urcd_pkg;

  localparam logic FUNC_SEGMENT = 1'b0;
  localparam logic FUNC_BIND    = 1'b1;

  localparam logic [15:0] UDP_PROTO     = 16'd17;
  localparam logic [7:0]  ETH_HDR_BYTES = 8'd14;
  localparam logic [15:0] UDP_HDR_BYTES = 16'd8;
  localparam logic [3:0]  IP_WORDS_MIN  = 4'd5;
  localparam logic [15:0] CSUM_GOOD     = 16'hFFFF;
  localparam logic [15:0] WORD_IDX_MAX  = 16'hFFFF;

  typedef enum logic [1:0] {
    ST_ACCEPTED  = 2'd0,
    ST_BAD_LEN   = 2'd1,
    ST_BAD_CSUM  = 2'd2,
    ST_NO_SOCKET = 2'd3
  } status_t;

  typedef struct packed {
    logic        en;
    logic [2:0]  slot;
    logic [15:0] port;
    logic        enable;
  } bind_wr_t;

endpackage

>>> hdl/udp_receive_check_and_demux_top.sv
// Checks received UDP segments word by word and steers each good one to a bound socket slot.
// Every input beat is registered, then the one's complement sum, the header capture and the
// port lookup are done combinationally ahead of the result register, so one beat (segment
// word or bind) is taken every cycle at full rate; a last word passes the input register and
// then the result register to the output. Only the last word of a segment yields a result
// beat. Bind beats and words other than a last word keep flowing while a verdict waits to be
// taken; a further last word holds in the input register until the verdict is taken.
module udp_receive_check_and_demux_top
  import urcd_pkg::*;
#(
  parameter int SOCKETS = 8
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        func,
  input  logic [2:0]  slot,
  input  logic [15:0] bind_port,
  input  logic        bind_enable,
  input  logic [31:0] src_addr,
  input  logic [31:0] dst_addr,
  input  logic [16:0] frame_len,
  input  logic [3:0]  ip_header_words,
  input  logic        first_word,
  input  logic [15:0] segment_word,
  input  logic        last_word,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  status,
  output logic [2:0]  socket_slot,
  output logic [15:0] payload_len,
  output logic [15:0] source_port
);

  // input register
  logic        s1_valid;
  logic        s1_func;
  logic [2:0]  s1_slot;
  logic [15:0] s1_bind_port;
  logic        s1_bind_enable;
  logic [31:0] s1_src_addr;
  logic [31:0] s1_dst_addr;
  logic [16:0] s1_frame_len;
  logic [3:0]  s1_ip_words;
  logic        s1_first;
  logic [15:0] s1_word;
  logic        s1_last;

  // segment state
  logic [15:0] running_sum;
  logic [15:0] word_index;
  logic [15:0] latched_src_port;
  logic [15:0] latched_dst_port;
  logic [15:0] latched_udp_len;
  logic        checksum_absent;
  logic [16:0] latched_frame_len;
  logic [3:0]  latched_ip_words;

  logic [15:0] running_sum_next;
  logic [15:0] word_index_next;
  logic [15:0] latched_src_port_next;
  logic [15:0] latched_dst_port_next;
  logic [15:0] latched_udp_len_next;
  logic        checksum_absent_next;
  logic [16:0] latched_frame_len_next;
  logic [3:0]  latched_ip_words_next;

  // result register
  logic        out_valid_r;
  status_t     status_r;
  logic [2:0]  socket_slot_r;
  logic [15:0] payload_len_r;
  logic [15:0] source_port_r;

  logic        s1_segment;
  logic        s1_result;
  logic        s1_fire;
  logic [15:0] idx;
  logic [15:0] base;
  logic [15:0] addr_a, addr_b, addr_c, addr_d;
  logic [15:0] proto_term, len_term, data_term;
  logic [16:0] byte_pos;
  logic [18:0] sum_wide;
  logic [16:0] sum_fold;
  logic [7:0]  hdr_bytes;
  logic        bad_len;
  logic        bad_csum;
  status_t     status_next;
  logic [15:0] payload_next;
  bind_wr_t    bind_wr;
  logic        hit;
  logic [2:0]  hit_slot;

  assign s1_segment = s1_func == FUNC_SEGMENT;
  assign s1_result  = s1_segment && s1_last;
  assign s1_fire    = s1_valid && (!s1_result || !out_valid_r || out_ready);
  assign in_ready   = !s1_valid || s1_fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_func        <= func;
      s1_slot        <= slot;
      s1_bind_port   <= bind_port;
      s1_bind_enable <= bind_enable;
      s1_src_addr    <= src_addr;
      s1_dst_addr    <= dst_addr;
      s1_frame_len   <= frame_len;
      s1_ip_words    <= ip_header_words;
      s1_first       <= first_word;
      s1_word        <= segment_word;
      s1_last        <= last_word;
    end
  end

  // header capture
  always_comb begin
    idx                    = s1_first ? '0 : word_index;
    latched_src_port_next  = s1_first ? '0 : latched_src_port;
    latched_dst_port_next  = s1_first ? '0 : latched_dst_port;
    latched_udp_len_next   = s1_first ? '0 : latched_udp_len;
    checksum_absent_next   = s1_first ? 1'b1 : checksum_absent;
    latched_frame_len_next = s1_first ? s1_frame_len : latched_frame_len;
    latched_ip_words_next  = s1_first ? s1_ip_words : latched_ip_words;
    case (idx)
      16'd0:   latched_src_port_next = s1_word;
      16'd1:   latched_dst_port_next = s1_word;
      16'd2:   latched_udp_len_next  = s1_word;
      16'd3:   checksum_absent_next  = s1_word == '0;
      default: ;
    endcase
    word_index_next = (idx != WORD_IDX_MAX) ? idx + 16'd1 : idx;
  end

  // one's complement sum: all terms of this beat in one adder, then two end-around folds
  always_comb begin
    base       = s1_first ? '0 : running_sum;
    addr_a     = s1_first ? s1_src_addr[31:16] : '0;
    addr_b     = s1_first ? s1_src_addr[15:0]  : '0;
    addr_c     = s1_first ? s1_dst_addr[31:16] : '0;
    addr_d     = s1_first ? s1_dst_addr[15:0]  : '0;
    proto_term = (idx == 16'd2) ? UDP_PROTO : '0;
    len_term   = (idx == 16'd2) ? s1_word : '0;
    byte_pos   = {idx, 1'b0};
    if (idx < 16'd2) begin
      data_term = s1_word;
    end else if (byte_pos + 17'd1 < {1'b0, latched_udp_len_next}) begin
      data_term = s1_word;
    end else if (byte_pos < {1'b0, latched_udp_len_next}) begin
      data_term = {s1_word[15:8], 8'h00};
    end else begin
      data_term = '0;
    end
    sum_wide = 19'(base) + 19'(addr_a) + 19'(addr_b) + 19'(addr_c) + 19'(addr_d)
             + 19'(proto_term) + 19'(len_term) + 19'(data_term);
    sum_fold = 17'(sum_wide[15:0]) + 17'(sum_wide[18:16]);
    running_sum_next = sum_fold[15:0] + 16'(sum_fold[16]);
  end

  assign bind_wr.en     = s1_fire && !s1_segment && 32'(s1_slot) < SOCKETS;
  assign bind_wr.slot   = s1_slot;
  assign bind_wr.port   = s1_bind_port;
  assign bind_wr.enable = s1_bind_enable;

  urcd_match #(
    .SOCKETS (SOCKETS)
  ) u_match (
    .clk         (clk),
    .rst         (rst),
    .bind_wr     (bind_wr),
    .lookup_port (latched_dst_port_next),
    .hit         (hit),
    .hit_slot    (hit_slot)
  );

  // verdict
  always_comb begin
    hdr_bytes = ETH_HDR_BYTES + {2'b00, latched_ip_words_next, 2'b00};
    bad_len   = 18'(latched_frame_len_next) < 18'(hdr_bytes) + 18'(UDP_HDR_BYTES)
             || 18'(latched_frame_len_next) != 18'(hdr_bytes) + 18'(latched_udp_len_next);
    bad_csum  = !checksum_absent_next && running_sum_next != CSUM_GOOD;
    if (bad_len) begin
      status_next = ST_BAD_LEN;
    end else if (bad_csum) begin
      status_next = ST_BAD_CSUM;
    end else if (!hit) begin
      status_next = ST_NO_SOCKET;
    end else begin
      status_next = ST_ACCEPTED;
    end
    payload_next = (latched_udp_len_next >= UDP_HDR_BYTES)
                 ? latched_udp_len_next - UDP_HDR_BYTES : '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running_sum       <= '0;
      word_index        <= '0;
      latched_src_port  <= '0;
      latched_dst_port  <= '0;
      latched_udp_len   <= '0;
      checksum_absent   <= 1'b0;
      latched_frame_len <= '0;
      latched_ip_words  <= IP_WORDS_MIN;
    end else if (s1_fire && s1_segment) begin
      running_sum       <= running_sum_next;
      word_index        <= word_index_next;
      latched_src_port  <= latched_src_port_next;
      latched_dst_port  <= latched_dst_port_next;
      latched_udp_len   <= latched_udp_len_next;
      checksum_absent   <= checksum_absent_next;
      latched_frame_len <= latched_frame_len_next;
      latched_ip_words  <= latched_ip_words_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid_r <= 1'b0;
    end else if (s1_fire && s1_result) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire && s1_result) begin
      status_r      <= status_next;
      socket_slot_r <= (status_next == ST_ACCEPTED) ? hit_slot : '0;
      payload_len_r <= payload_next;
      source_port_r <= latched_src_port_next;
    end
  end

  assign out_valid   = out_valid_r;
  assign status      = status_r;
  assign socket_slot = socket_slot_r;
  assign payload_len = payload_len_r;
  assign source_port = source_port_r;

endmodule

>>> hdl/urcd_match.sv
// socket port table with lowest-slot port lookup
module urcd_match
  import urcd_pkg::*;
#(
  parameter int SOCKETS = 8
) (
  input  logic        clk,
  input  logic        rst,
  input  bind_wr_t    bind_wr,
  input  logic [15:0] lookup_port,
  output logic        hit,
  output logic [2:0]  hit_slot
);

  logic [15:0]        port_table [SOCKETS];
  logic [SOCKETS-1:0] port_valid;

  always_ff @(posedge clk) begin
    for (int i = 0; i < SOCKETS; i++) begin
      if (bind_wr.en && 32'(bind_wr.slot) == i) begin
        port_table[i] <= bind_wr.port;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      port_valid <= '0;
    end else begin
      for (int i = 0; i < SOCKETS; i++) begin
        if (bind_wr.en && 32'(bind_wr.slot) == i) begin
          port_valid[i] <= bind_wr.enable;
        end
      end
    end
  end

  // scan from the top so the lowest matching slot wins
  always_comb begin
    hit      = 1'b0;
    hit_slot = '0;
    for (int i = SOCKETS - 1; i >= 0; i--) begin
      if (port_valid[i] && port_table[i] == lookup_port) begin
        hit      = 1'b1;
        hit_slot = 3'(i);
      end
    end
  end

endmodule
